[rtl/lsvm_pkg.sv]
package lsvm_pkg;

    // Request kinds carried on the input tuser.
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_RESTART = 2'd1;
    localparam logic [1:0] MODE_MIX     = 2'd2;

    // Loop behaviour at the end of the sample.
    localparam logic [1:0] LOOP_STOP     = 2'd0;
    localparam logic [1:0] LOOP_FORWARD  = 2'd1;
    localparam logic [1:0] LOOP_PINGPONG = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STEP           = 3'd0;
    localparam logic [2:0] REG_LOOP_START     = 3'd1;
    localparam logic [2:0] REG_LOOP_END       = 3'd2;
    localparam logic [2:0] REG_LOOP_MODE      = 3'd3;
    localparam logic [2:0] REG_SAMPLE_WIDTH   = 3'd4;
    localparam logic [2:0] REG_GAIN           = 3'd5;
    localparam logic [2:0] REG_START_POSITION = 3'd6;

    // Reset values of the registers that are not zero.
    localparam logic [15:0] STEP_RESET     = 16'd256;
    localparam logic [23:0] LOOP_END_RESET = 24'hFFFFFF;

    // Saturation bounds of the mixed output.
    localparam logic signed [17:0] SAT_POS = 18'sd32767;
    localparam logic signed [17:0] SAT_NEG = -18'sd32767;

    typedef struct packed {
        logic [15:0] step;
        logic [23:0] loop_start;
        logic [23:0] loop_end;
        logic [1:0]  loop_mode;
        logic        sample_width;
        logic [15:0] gain;
        logic [23:0] start_position;
    } lsvm_cfg_t;

    // Control that travels with a request from the voice stage to the mixer.
    typedef struct packed {
        logic is_mix;
        logic add_en;
        logic lane;
        logic active;
    } lsvm_ctl_t;

endpackage

[rtl/lsvm_ram.sv]
module lsvm_ram #(
    parameter int AW = 15,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    localparam int DEPTH = 2 ** AW;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/lsvm_voice.sv]
module lsvm_voice
    import lsvm_pkg::*;
#(
    parameter int WORD_W = 15
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [1:0]        mode,
    input  lsvm_cfg_t         cfg,
    output logic [WORD_W-1:0] rd_word,
    output lsvm_ctl_t         ctl
);

    logic [23:0] position_reg, position_next;
    logic        backward_reg, backward_next;
    logic        active_reg, active_next;

    logic [23:0] pos_loop;
    logic        bw_loop;
    logic        act_loop;
    logic [23:0] pos_step;
    logic [15:0] sample_idx;
    logic [31:0] word_wide;
    logic        is_mix;

    assign is_mix = (mode == MODE_MIX);

    // Loop handling ahead of the sample fetch.
    always_comb begin
        pos_loop = position_reg;
        bw_loop  = backward_reg;
        act_loop = active_reg;
        if (is_mix && active_reg) begin
            if (backward_reg) begin
                if (position_reg <= cfg.loop_start) begin
                    bw_loop  = 1'b0;
                    pos_loop = {cfg.loop_start[22:0], 1'b0} - position_reg;
                end
            end else if (position_reg >= cfg.loop_end) begin
                unique case (cfg.loop_mode)
                    LOOP_STOP: begin
                        act_loop = 1'b0;
                    end
                    LOOP_PINGPONG: begin
                        bw_loop  = 1'b1;
                        pos_loop = {cfg.loop_end[22:0], 1'b0} - position_reg;
                    end
                    default: begin
                        pos_loop = position_reg + cfg.loop_start - cfg.loop_end;
                    end
                endcase
            end
        end
    end

    // Advance by the step in the current direction.
    assign pos_step = bw_loop ? (pos_loop - {8'd0, cfg.step}) : (pos_loop + {8'd0, cfg.step});

    always_comb begin
        position_next = position_reg;
        backward_next = backward_reg;
        active_next   = active_reg;
        unique case (mode)
            MODE_RESTART: begin
                position_next = cfg.start_position;
                backward_next = 1'b0;
                active_next   = 1'b1;
            end
            MODE_MIX: begin
                position_next = act_loop ? pos_step : pos_loop;
                backward_next = bw_loop;
                active_next   = act_loop;
            end
            default: begin
                position_next = position_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            position_reg <= '0;
            backward_reg <= 1'b0;
            active_reg   <= 1'b0;
        end else if (accept) begin
            position_reg <= position_next;
            backward_reg <= backward_next;
            active_reg   <= active_next;
        end
    end

    // Word address into the two byte banks: one word holds a 16-bit sample,
    // or two 8-bit samples of which the low index bit picks the bank.
    assign sample_idx = pos_loop[23:8];
    assign word_wide  = cfg.sample_width ? {16'd0, sample_idx} : {17'd0, sample_idx[15:1]};
    assign rd_word    = word_wide[WORD_W-1:0];

    assign ctl.is_mix = is_mix;
    assign ctl.add_en = is_mix && act_loop;
    assign ctl.lane   = sample_idx[0];
    assign ctl.active = active_next;

    a_restart_plays: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && accept && (mode == MODE_RESTART) |=> active_reg && !backward_reg)
        else $error("voice not playing forward after a restart");

    a_stop_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) && $past(aresetn)
        |-> $past(accept && (mode == MODE_MIX) && (cfg.loop_mode == LOOP_STOP)))
        else $error("voice stopped without a mix request in stop mode");

endmodule

[rtl/lsvm_mix.sv]
module lsvm_mix
    import lsvm_pkg::*;
(
    input  logic        aclk,
    input  logic        en2,
    input  logic        en_out,
    input  lsvm_ctl_t   ctl1,
    input  logic [15:0] left1,
    input  logic [15:0] right1,
    input  logic [7:0]  even_byte,
    input  logic [7:0]  odd_byte,
    input  logic        sample_width,
    input  logic [15:0] gain,
    output logic [15:0] out_left,
    output logic [15:0] out_right,
    output logic        out_active
);

    logic [7:0]         byte_sel;
    logic [15:0]        sample;
    logic signed [32:0] gain_x;
    logic signed [32:0] sample_x;
    logic signed [32:0] prod;

    logic signed [32:0] prod_reg;
    logic               wide_reg;
    lsvm_ctl_t          ctl2_reg;
    logic [15:0]        left2_reg;
    logic [15:0]        right2_reg;

    logic signed [32:0] shifted;
    logic signed [17:0] add;
    logic signed [17:0] sum_l;
    logic signed [17:0] sum_r;
    logic [15:0]        sat_l;
    logic [15:0]        sat_r;

    logic [15:0]        out_left_reg;
    logic [15:0]        out_right_reg;
    logic               out_active_reg;

    // Build the signed sample from the two banks and scale it by the gain.
    assign byte_sel = ctl1.lane ? odd_byte : even_byte;
    assign sample   = sample_width ? {odd_byte, even_byte} : {{8{byte_sel[7]}}, byte_sel};
    assign gain_x   = {17'd0, gain};
    assign sample_x = {{17{sample[15]}}, sample};
    assign prod     = ctl1.add_en ? gain_x * sample_x : '0;

    always_ff @(posedge aclk) begin
        if (en2) begin
            prod_reg   <= prod;
            wide_reg   <= sample_width;
            ctl2_reg   <= ctl1;
            left2_reg  <= left1;
            right2_reg <= right1;
        end
    end

    // Floor division by the sample scale is an arithmetic shift.
    assign shifted = wide_reg ? (prod_reg >>> 16) : (prod_reg >>> 8);
    assign add     = shifted[17:0];
    assign sum_l   = {{2{left2_reg[15]}}, left2_reg} + add;
    assign sum_r   = {{2{right2_reg[15]}}, right2_reg} + add;

    always_comb begin
        priority if (sum_l > SAT_POS) begin
            sat_l = SAT_POS[15:0];
        end else if (sum_l < SAT_NEG) begin
            sat_l = SAT_NEG[15:0];
        end else begin
            sat_l = sum_l[15:0];
        end
        priority if (sum_r > SAT_POS) begin
            sat_r = SAT_POS[15:0];
        end else if (sum_r < SAT_NEG) begin
            sat_r = SAT_NEG[15:0];
        end else begin
            sat_r = sum_r[15:0];
        end
    end

    // Output register; loads and restarts report zero levels.
    always_ff @(posedge aclk) begin
        if (en_out) begin
            out_left_reg   <= ctl2_reg.is_mix ? sat_l : 16'd0;
            out_right_reg  <= ctl2_reg.is_mix ? sat_r : 16'd0;
            out_active_reg <= ctl2_reg.active;
        end
    end

    assign out_left   = out_left_reg;
    assign out_right  = out_right_reg;
    assign out_active = out_active_reg;

endmodule

[rtl/looping_sample_voice_mixer.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tuser mode, s_tdata load and mix fields
// m_        out        m_tvalid/m_tready  m_tdata mixed levels and voice state
// APB       in         psel/penable       seven voice registers, 4-byte stride
//
// One request is taken every cycle unless a stall on m_tready holds the pipeline; its result
// passes through the sample read, the gain multiply and the output register.
// The rate is set by the position update, which resolves looping and the step together.
// Reset clears the voice and the pipeline; sample memory is not cleared and
// holds whatever was loaded.
// A stall on m_tready holds the output; the pipeline then fills and s_tready drops.
module looping_sample_voice_mixer
    import lsvm_pkg::*;
#(
    parameter int SAMPLE_BYTES = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] load_address, [23:16] load_byte, [39:24] mix_left, [55:40] mix_right
    input  logic [55:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] out_left, [31:16] out_right, [32] voice_active, [39:33] zero
    output logic [39:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WORD_W = $clog2(SAMPLE_BYTES) - 1;

    lsvm_cfg_t cfg_reg;

    logic        v1_reg;
    logic        v2_reg;
    logic        m_valid_reg;
    logic        en1;
    logic        en2;
    logic        en_out;
    logic        accept;

    logic [WORD_W-1:0] rd_word;
    logic [31:0]       ld_word_wide;
    logic [WORD_W-1:0] wr_word;
    logic              we_load;
    logic [7:0]        even_byte;
    logic [7:0]        odd_byte;

    lsvm_ctl_t   ctl0;
    lsvm_ctl_t   ctl1_reg;
    logic [15:0] left1_reg;
    logic [15:0] right1_reg;

    logic [15:0] out_left;
    logic [15:0] out_right;
    logic        out_active;
    logic [2:0]  reg_idx;
    logic        cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step           <= STEP_RESET;
            cfg_reg.loop_start     <= '0;
            cfg_reg.loop_end       <= LOOP_END_RESET;
            cfg_reg.loop_mode      <= LOOP_STOP;
            cfg_reg.sample_width   <= 1'b0;
            cfg_reg.gain           <= '0;
            cfg_reg.start_position <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_STEP:           cfg_reg.step           <= pwdata[15:0];
                REG_LOOP_START:     cfg_reg.loop_start     <= pwdata[23:0];
                REG_LOOP_END:       cfg_reg.loop_end       <= pwdata[23:0];
                REG_LOOP_MODE:      cfg_reg.loop_mode      <= pwdata[1:0];
                REG_SAMPLE_WIDTH:   cfg_reg.sample_width   <= pwdata[0];
                REG_GAIN:           cfg_reg.gain           <= pwdata[15:0];
                REG_START_POSITION: cfg_reg.start_position <= pwdata[23:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_STEP:           prdata = {16'd0, cfg_reg.step};
            REG_LOOP_START:     prdata = {8'd0, cfg_reg.loop_start};
            REG_LOOP_END:       prdata = {8'd0, cfg_reg.loop_end};
            REG_LOOP_MODE:      prdata = {30'd0, cfg_reg.loop_mode};
            REG_SAMPLE_WIDTH:   prdata = {31'd0, cfg_reg.sample_width};
            REG_GAIN:           prdata = {16'd0, cfg_reg.gain};
            REG_START_POSITION: prdata = {8'd0, cfg_reg.start_position};
            default:            prdata = 32'd0;
        endcase
    end

    // Pipeline flow: each stage loads when it is empty or the next one moves.
    assign en_out   = !m_valid_reg || m_tready;
    assign en2      = !v2_reg || en_out;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign accept   = s_tvalid && en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
            if (en_out) begin
                m_valid_reg <= v2_reg;
            end
        end
    end

    // Voice position, direction and loop handling.
    lsvm_voice #(
        .WORD_W (WORD_W)
    ) u_voice (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .mode    (s_tuser),
        .cfg     (cfg_reg),
        .rd_word (rd_word),
        .ctl     (ctl0)
    );

    // Sample memory as even and odd byte banks, so a 16-bit sample is one read.
    assign ld_word_wide = {17'd0, s_tdata[15:1]};
    assign wr_word      = ld_word_wide[WORD_W-1:0];
    assign we_load      = accept && (s_tuser == MODE_LOAD);

    lsvm_ram #(
        .AW (WORD_W),
        .DW (8)
    ) u_ram_even (
        .aclk  (aclk),
        .we    (we_load && !s_tdata[0]),
        .waddr (wr_word),
        .wdata (s_tdata[23:16]),
        .re    (en1),
        .raddr (rd_word),
        .rdata (even_byte)
    );

    lsvm_ram #(
        .AW (WORD_W),
        .DW (8)
    ) u_ram_odd (
        .aclk  (aclk),
        .we    (we_load && s_tdata[0]),
        .waddr (wr_word),
        .wdata (s_tdata[23:16]),
        .re    (en1),
        .raddr (rd_word),
        .rdata (odd_byte)
    );

    // Request fields that wait beside the memory read.
    always_ff @(posedge aclk) begin
        if (en1) begin
            ctl1_reg   <= ctl0;
            left1_reg  <= s_tdata[39:24];
            right1_reg <= s_tdata[55:40];
        end
    end

    lsvm_mix u_mix (
        .aclk         (aclk),
        .en2          (en2),
        .en_out       (en_out),
        .ctl1         (ctl1_reg),
        .left1        (left1_reg),
        .right1       (right1_reg),
        .even_byte    (even_byte),
        .odd_byte     (odd_byte),
        .sample_width (cfg_reg.sample_width),
        .gain         (cfg_reg.gain),
        .out_left     (out_left),
        .out_right    (out_right),
        .out_active   (out_active)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, out_active, out_right, out_left};

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && m_valid_reg)
        else $error("input blocked while the pipeline has room");

    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
        else $error("mixed level outside the saturation range");

endmodule
